>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XLF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xlf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define XLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xlf assertion failed");

`endif

>>> sv/xlf_pkg.sv
// ---------------------------------------------------------------------------
// xlf_pkg
// Types and constants for the x86 lazy flags evaluator.
// ---------------------------------------------------------------------------
package xlf_pkg;

    // Fixed bits of the packed EFLAGS word: reserved bit 1 and IF.
    localparam logic [31:0] EFL_FIXED = 32'h0000_0202;

    // Bit positions inside the packed word.
    localparam int unsigned EFL_CF_BIT = 0;
    localparam int unsigned EFL_PF_BIT = 2;
    localparam int unsigned EFL_AF_BIT = 4;
    localparam int unsigned EFL_ZF_BIT = 6;
    localparam int unsigned EFL_SF_BIT = 7;
    localparam int unsigned EFL_OF_BIT = 11;

    // Recorded operation kinds; codes above OP_NONE behave as OP_NONE.
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_LOGIC = 4'd2,
        OP_SHL  = 4'd3,
        OP_SHR  = 4'd4,
        OP_SAR  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_NONE = 4'd8
    } t_op_kind;

    // Operand width after decoding size_bytes.
    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2
    } t_width;

    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_WORD = 3'd2;

endpackage

>>> sv/x86_lazy_flags_eval.sv
// ---------------------------------------------------------------------------
// x86_lazy_flags_eval
// Derives CF, PF, AF, ZF, SF and OF from a lazy operation record, or
// restores them from a saved flags word, and packs them into EFLAGS.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive the record fields and pulse i_start. A request is
//   taken at every rising edge with i_start high and o_busy low; o_busy is
//   held low, so a request may be issued in every cycle.
//   Result channel: o_valid marks the single cycle in which the flags and
//   the packed word are on the o_ ports. The receiver cannot stall; a
//   result it does not capture in that cycle is gone.
//   A request passes the input register, then the result register, before
//   its result is out. Throughput: 1 request per cycle, set by the single
//   combinational flag stage between the two register ranks.
//   Reset (i_rst_n low, synchronous): drop any request in flight; the
//   valid bits clear, payload registers are left as they are.
//   i_func high restores CF, ZF and SF from i_saved_flags, copies ZF into
//   PF and clears AF and OF. Sizes other than 1 or 2 bytes count as 4;
//   op_kind codes above 8 act as "none".
// ---------------------------------------------------------------------------
module x86_lazy_flags_eval
    import xlf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_func,
    input  logic [3:0]  i_op_kind,
    input  logic [2:0]  i_size_bytes,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [31:0] i_result_value,
    input  logic        i_carry_hint,
    input  logic [31:0] i_saved_flags,
    output logic        o_valid,
    output logic        o_carry_flag,
    output logic        o_parity_flag,
    output logic        o_aux_flag,
    output logic        o_zero_flag,
    output logic        o_sign_flag,
    output logic        o_overflow_flag,
    output logic [31:0] o_packed_flags
);

    // Input register rank.
    logic        r_in_vld;
    logic        r_func;
    logic [3:0]  r_kind;
    logic [2:0]  r_size;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_res;
    logic        r_hint;
    logic [31:0] r_saved;

    // Result register rank.
    logic        r_out_vld;
    logic        r_cf, r_pf, r_af, r_zf, r_sf, r_of;
    logic [31:0] r_packed;

    // Next values of the result rank.
    logic        n_cf, n_pf, n_af, n_zf, n_sf, n_of;
    logic [31:0] n_packed;

    // Helpers of the flag stage.
    t_width      width;
    logic [5:0]  width_bits;
    logic [31:0] mask;
    logic [31:0] top;
    logic [31:0] a_m, b_m, res_m;
    logic        res_top, a_top;
    logic        add_ovf, sub_ovf;
    logic [5:0]  shl_pos;
    logic [4:0]  shr_pos;
    logic        ev_cf, ev_of;

    // Never stall the request side.
    assign o_busy = 1'b0;

    // Capture each request; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start && !o_busy;
        end
        if (i_start && !o_busy) begin
            r_func  <= i_func;
            r_kind  <= i_op_kind;
            r_size  <= i_size_bytes;
            r_a     <= i_operand_a;
            r_b     <= i_operand_b;
            r_res   <= i_result_value;
            r_hint  <= i_carry_hint;
            r_saved <= i_saved_flags;
        end
    end

    // Decode the operand width.
    always_comb begin
        if (r_size == SIZE_BYTE) begin
            width = W8;
        end else if (r_size == SIZE_WORD) begin
            width = W16;
        end else begin
            width = W32;
        end
    end

    always_comb begin
        unique case (width)
            W8: begin
                width_bits = 6'd8;
                mask       = 32'h0000_00ff;
                top        = 32'h0000_0080;
            end
            W16: begin
                width_bits = 6'd16;
                mask       = 32'h0000_ffff;
                top        = 32'h0000_8000;
            end
            default: begin
                width_bits = 6'd32;
                mask       = 32'hffff_ffff;
                top        = 32'h8000_0000;
            end
        endcase
    end

    assign a_m     = r_a & mask;
    assign b_m     = r_b & mask;
    assign res_m   = r_res & mask;
    assign res_top = |(r_res & top);
    assign a_top   = |(r_a & top);

    // Overflow terms test the top bit of the unmasked values.
    assign add_ovf = |(~(r_a ^ r_b) & (r_a ^ r_res) & top);
    assign sub_ovf = |((r_a ^ r_b) & (r_a ^ r_res) & top);

    // Shift carry positions read the full 32-bit operand.
    assign shl_pos = width_bits - r_b[5:0];
    assign shr_pos = r_b[4:0] - 5'd1;

    // Carry and overflow of the lazy record.
    always_comb begin
        ev_cf = r_hint;
        ev_of = 1'b0;
        unique case (r_kind)
            OP_ADD: begin
                ev_cf = res_m < a_m;
                ev_of = add_ovf;
            end
            OP_SUB: begin
                ev_cf = a_m < b_m;
                ev_of = sub_ovf;
            end
            OP_LOGIC: begin
                ev_cf = 1'b0;
            end
            OP_SHL: begin
                // Counts of zero or beyond the width shift nothing out.
                if (r_b == 32'd0 || r_b > {26'd0, width_bits}) begin
                    ev_cf = 1'b0;
                end else begin
                    ev_cf = r_a[shl_pos[4:0]];
                end
                ev_of = res_top ^ ev_cf;
            end
            OP_SHR, OP_SAR: begin
                if (r_b == 32'd0 || r_b > 32'd32) begin
                    ev_cf = 1'b0;
                end else begin
                    ev_cf = r_a[shr_pos];
                end
                ev_of = (r_kind == OP_SHR) && (r_b == 32'd1) && a_top;
            end
            OP_INC: begin
                ev_of = res_m == top;
            end
            OP_DEC: begin
                ev_of = res_m == (top - 32'd1);
            end
            default: begin
                ev_cf = r_hint;
            end
        endcase
    end

    // Pick between evaluation and restore, then pack.
    always_comb begin
        if (r_func) begin
            n_cf = r_saved[EFL_CF_BIT];
            n_zf = r_saved[EFL_ZF_BIT];
            n_sf = r_saved[EFL_SF_BIT];
            n_pf = r_saved[EFL_ZF_BIT];
            n_af = 1'b0;
            n_of = 1'b0;
        end else begin
            n_cf = ev_cf;
            n_zf = res_m == 32'd0;
            n_sf = res_top;
            n_pf = ~^r_res[7:0];
            n_af = r_a[EFL_AF_BIT] ^ r_b[EFL_AF_BIT] ^ r_res[EFL_AF_BIT];
            n_of = ev_of;
        end
        n_packed             = EFL_FIXED;
        n_packed[EFL_CF_BIT] = n_cf;
        n_packed[EFL_PF_BIT] = n_pf;
        n_packed[EFL_AF_BIT] = n_af;
        n_packed[EFL_ZF_BIT] = n_zf;
        n_packed[EFL_SF_BIT] = n_sf;
        n_packed[EFL_OF_BIT] = n_of;
    end

    // Result rank: one strobe per request, one cycle wide.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        if (r_in_vld) begin
            r_cf     <= n_cf;
            r_pf     <= n_pf;
            r_af     <= n_af;
            r_zf     <= n_zf;
            r_sf     <= n_sf;
            r_of     <= n_of;
            r_packed <= n_packed;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_carry_flag    = r_cf;
    assign o_parity_flag   = r_pf;
    assign o_aux_flag      = r_af;
    assign o_zero_flag     = r_zf;
    assign o_sign_flag     = r_sf;
    assign o_overflow_flag = r_of;
    assign o_packed_flags  = r_packed;

endmodule

>>> sv/xlf_checker.sv
// ---------------------------------------------------------------------------
// xlf_checker
// Port-level checks for the lazy flags evaluator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xlf_checker
    import xlf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        i_func,
    input logic        o_valid,
    input logic        o_carry_flag,
    input logic        o_parity_flag,
    input logic        o_aux_flag,
    input logic        o_zero_flag,
    input logic        o_sign_flag,
    input logic        o_overflow_flag,
    input logic [31:0] o_packed_flags
);

    logic req;
    logic restore_req;
    logic restore_ok;
    logic flags_match;

    assign req         = i_start && !o_busy;
    assign restore_req = req && i_func;

    // Restore clears AF and OF and mirrors ZF into PF.
    assign restore_ok = !o_aux_flag && !o_overflow_flag && (o_parity_flag == o_zero_flag);

    // Packed word agrees with the single flags and carries the fixed bits.
    assign flags_match = o_packed_flags[EFL_CF_BIT] == o_carry_flag
                      && o_packed_flags[EFL_PF_BIT] == o_parity_flag
                      && o_packed_flags[EFL_AF_BIT] == o_aux_flag
                      && o_packed_flags[EFL_ZF_BIT] == o_zero_flag
                      && o_packed_flags[EFL_SF_BIT] == o_sign_flag
                      && o_packed_flags[EFL_OF_BIT] == o_overflow_flag
                      && (o_packed_flags & EFL_FIXED) == EFL_FIXED;

    `XLF_ASSERT_NOW(a_packed_consistent, o_valid, flags_match)
    `XLF_ASSERT_NEXT(a_request_answered, req, ##1 o_valid)
    `XLF_ASSERT_NOW(a_no_spurious_result, o_valid, $past(req, 2))
    `XLF_ASSERT_NOW(a_restore_flags, o_valid && $past(restore_req, 2), restore_ok)

endmodule

bind x86_lazy_flags_eval xlf_checker u_xlf_checker (.*);

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the x86 lazy flags evaluator. A short directed set
// hits the flag corners of every operation kind, restore from a saved flags
// word, odd sizes and unknown kinds; a long random run follows, mostly with
// results that match their operands. Every request is predicted in the bench
// and each strobed result is compared field by field, in order.
// ---------------------------------------------------------------------------
module tb_top
    import xlf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] SIZE_DWORD = 3'd4;
    localparam logic FUNC_EVAL = 1'b0;
    localparam logic FUNC_RESTORE = 1'b1;
    localparam int unsigned RANDOM_REQUESTS = 1150;
    localparam int unsigned STALL_LIMIT = 200;
    localparam int unsigned TAIL_CYCLES = 4;

    // One lazy record as the driver presents it; gap = idle cycles before it.
    typedef struct packed {
        logic        func;
        logic [3:0]  op_kind;
        logic [2:0]  size;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        logic        hint;
        logic [31:0] saved;
        logic [3:0]  gap;
    } t_request;

    typedef struct packed {
        logic        cf;
        logic        pf;
        logic        af;
        logic        zf;
        logic        sf;
        logic        of;
        logic [31:0] word;
    } t_flags;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_func = 1'b0;
    logic [3:0]  i_op_kind = '0;
    logic [2:0]  i_size_bytes = '0;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    logic [31:0] i_result_value = '0;
    logic        i_carry_hint = 1'b0;
    logic [31:0] i_saved_flags = '0;
    logic        o_busy;
    logic        o_valid;
    logic        o_carry_flag;
    logic        o_parity_flag;
    logic        o_aux_flag;
    logic        o_zero_flag;
    logic        o_sign_flag;
    logic        o_overflow_flag;
    logic [31:0] o_packed_flags;

    t_request    pending_requests[$];
    t_flags      expected_flags[$];
    t_request    in_flight;
    t_flags      want;
    int unsigned gap_waited = 0;
    int unsigned requests_total = 0;
    int unsigned requests_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    x86_lazy_flags_eval dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_func         (i_func),
        .i_op_kind      (i_op_kind),
        .i_size_bytes   (i_size_bytes),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_result_value (i_result_value),
        .i_carry_hint   (i_carry_hint),
        .i_saved_flags  (i_saved_flags),
        .o_valid        (o_valid),
        .o_carry_flag   (o_carry_flag),
        .o_parity_flag  (o_parity_flag),
        .o_aux_flag     (o_aux_flag),
        .o_zero_flag    (o_zero_flag),
        .o_sign_flag    (o_sign_flag),
        .o_overflow_flag(o_overflow_flag),
        .o_packed_flags (o_packed_flags)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Decode size_bytes: anything but one or two bytes counts as a dword.
    function automatic int unsigned width_of(input logic [2:0] size);
        case (size)
            SIZE_BYTE: return 8;
            SIZE_WORD: return 16;
            default:   return 32;
        endcase
    endfunction

    // Derive the six status flags and the packed EFLAGS word of one request.
    function automatic t_flags derive_flags(input t_request r);
        t_flags      f;
        int unsigned w;
        logic [31:0] mk;
        logic [31:0] m;
        logic [31:0] am;
        logic [31:0] bm;
        logic [31:0] rm;
        f = '0;
        if (r.func == FUNC_RESTORE) begin
            // Restore: keep CF, ZF and SF; PF mirrors ZF; AF and OF clear.
            f.cf = r.saved[EFL_CF_BIT];
            f.zf = r.saved[EFL_ZF_BIT];
            f.sf = r.saved[EFL_SF_BIT];
            f.pf = f.zf;
        end else begin
            w  = width_of(r.size);
            mk = (w == 32) ? 32'hffff_ffff : ((32'd1 << w) - 32'd1);
            m  = 32'd1 << (w - 1);
            am = r.a & mk;
            bm = r.b & mk;
            rm = r.res & mk;
            // Unknown kinds fall into the default arm, same as OP_NONE.
            case (r.op_kind)
                OP_ADD: begin
                    f.cf = rm < am;
                    f.of = ((~(r.a ^ r.b)) & (r.a ^ r.res) & m) != 0;
                end
                OP_SUB: begin
                    f.cf = am < bm;
                    f.of = ((r.a ^ r.b) & (r.a ^ r.res) & m) != 0;
                end
                OP_LOGIC: begin
                    f.cf = 1'b0;
                    f.of = 1'b0;
                end
                OP_SHL: begin
                    // Zero count or a count beyond the width leaves CF clear.
                    if (r.b == 0 || r.b > w) f.cf = 1'b0;
                    else f.cf = r.a[w - r.b];
                    f.of = ((r.res & m) != 0) ^ f.cf;
                end
                OP_SHR, OP_SAR: begin
                    // Last bit shifted out; counts past 32 shift out nothing.
                    if (r.b == 0 || r.b > 32) f.cf = 1'b0;
                    else f.cf = r.a[r.b - 32'd1];
                    f.of = (r.op_kind == OP_SHR) && (r.b == 1) && ((r.a & m) != 0);
                end
                OP_INC: begin
                    f.cf = r.hint;
                    f.of = (rm == m);
                end
                OP_DEC: begin
                    f.cf = r.hint;
                    f.of = (rm == m - 32'd1);
                end
                default: begin
                    f.cf = r.hint;
                    f.of = 1'b0;
                end
            endcase
            f.zf = (rm == 0);
            f.sf = (r.res & m) != 0;
            f.pf = ~^r.res[7:0];
            f.af = r.a[4] ^ r.b[4] ^ r.res[4];
        end
        f.word = EFL_FIXED;
        f.word[EFL_CF_BIT] = f.cf;
        f.word[EFL_PF_BIT] = f.pf;
        f.word[EFL_AF_BIT] = f.af;
        f.word[EFL_ZF_BIT] = f.zf;
        f.word[EFL_SF_BIT] = f.sf;
        f.word[EFL_OF_BIT] = f.of;
        return f;
    endfunction

    // Favor values that sit on flag boundaries.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return $urandom & 32'h0000_00ff;
            5:       return $urandom & 32'h0000_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_request random_request(input logic [3:0] gap);
        t_request    r;
        int unsigned w;
        r.func = ($urandom_range(0, 9) == 0) ? FUNC_RESTORE : FUNC_EVAL;
        if ($urandom_range(0, 9) == 0) r.op_kind = 4'($urandom_range(int'(OP_NONE) + 1, 15));
        else r.op_kind = 4'($urandom_range(int'(OP_ADD), int'(OP_NONE)));
        case ($urandom_range(0, 9))
            0, 1, 2: r.size = SIZE_BYTE;
            3, 4, 5: r.size = SIZE_WORD;
            6, 7, 8: r.size = SIZE_DWORD;
            default: r.size = 3'($urandom_range(0, 7));
        endcase
        w = width_of(r.size);
        r.a = pick_operand();
        r.b = pick_operand();
        r.res = $urandom;
        r.hint = 1'($urandom_range(0, 1));
        r.saved = $urandom;
        r.gap = gap;
        // Make most records consistent with their operands; leave some as noise.
        if ($urandom_range(0, 7) != 0) begin
            case (r.op_kind)
                OP_ADD:   r.res = r.a + r.b;
                OP_SUB:   r.res = r.a - r.b;
                OP_LOGIC: r.res = $urandom_range(0, 1) ? (r.a & r.b) : (r.a ^ r.b);
                OP_SHL, OP_SHR, OP_SAR: begin
                    r.b = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, w + 1);
                    r.res = (r.op_kind == OP_SHL) ? (r.a << r.b) : (r.a >> r.b);
                end
                OP_INC:   r.res = r.a + 32'd1;
                OP_DEC:   r.res = r.a - 32'd1;
                default:  ;
            endcase
        end
        return r;
    endfunction

    task automatic push_request(input t_request r);
        pending_requests.push_back(r);
        requests_total++;
    endtask

    task automatic queue_eval(input logic [3:0] kind, input logic [2:0] size,
                              input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] res, input logic hint);
        t_request r;
        r = '{func: FUNC_EVAL, op_kind: kind, size: size, a: a, b: b, res: res,
              hint: hint, saved: $urandom, gap: 4'd0};
        push_request(r);
    endtask

    task automatic queue_restore(input logic [31:0] saved);
        t_request r;
        r = random_request(4'd0);
        r.func = FUNC_RESTORE;
        r.saved = saved;
        push_request(r);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    // Driver: present one request at a time, hold it until taken, and
    // predict its flags at the edge that takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap_waited = 0;
        end else if (i_start && o_busy) begin
            // hold the current request
        end else begin
            if (i_start) begin
                expected_flags.push_back(derive_flags(in_flight));
                requests_taken++;
            end
            if (pending_requests.size() == 0) begin
                i_start <= 1'b0;
            end else if (gap_waited < pending_requests[0].gap) begin
                gap_waited++;
                i_start <= 1'b0;
            end else begin
                in_flight = pending_requests.pop_front();
                gap_waited = 0;
                i_start        <= 1'b1;
                i_func         <= in_flight.func;
                i_op_kind      <= in_flight.op_kind;
                i_size_bytes   <= in_flight.size;
                i_operand_a    <= in_flight.a;
                i_operand_b    <= in_flight.b;
                i_result_value <= in_flight.res;
                i_carry_hint   <= in_flight.hint;
                i_saved_flags  <= in_flight.saved;
            end
        end
    end

    // Monitor: take each strobed result and check it against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_flags.size() == 0) begin
                flag_mismatch("unexpected result", o_packed_flags, 32'h0);
            end else begin
                want = expected_flags.pop_front();
                if (o_carry_flag !== want.cf)
                    flag_mismatch("CF", 32'(o_carry_flag), 32'(want.cf));
                if (o_parity_flag !== want.pf)
                    flag_mismatch("PF", 32'(o_parity_flag), 32'(want.pf));
                if (o_aux_flag !== want.af)
                    flag_mismatch("AF", 32'(o_aux_flag), 32'(want.af));
                if (o_zero_flag !== want.zf)
                    flag_mismatch("ZF", 32'(o_zero_flag), 32'(want.zf));
                if (o_sign_flag !== want.sf)
                    flag_mismatch("SF", 32'(o_sign_flag), 32'(want.sf));
                if (o_overflow_flag !== want.of)
                    flag_mismatch("OF", 32'(o_overflow_flag), 32'(want.of));
                if (o_packed_flags !== want.word)
                    flag_mismatch("packed word", o_packed_flags, want.word);
            end
        end
    end

    // Watchdog: abort when neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic        no_idle;
        int unsigned n;
        logic [3:0]  gap;

        // Directed: carry, overflow, zero and aux corners of each kind.
        queue_eval(OP_ADD, SIZE_BYTE, 32'h0000_00ff, 32'h0000_0001, 32'h0000_0100, 1'b0);
        queue_eval(OP_ADD, SIZE_BYTE, 32'h0000_007f, 32'h0000_0001, 32'h0000_0080, 1'b1);
        queue_eval(OP_ADD, SIZE_DWORD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_fffe, 1'b0);
        queue_eval(OP_SUB, SIZE_WORD, 32'h0000_0000, 32'h0000_0001, 32'h0000_ffff, 1'b0);
        queue_eval(OP_SUB, SIZE_DWORD, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 1'b1);
        queue_eval(OP_LOGIC, SIZE_DWORD, 32'hf0f0_f0f0, 32'h0f0f_0f0f, 32'h0000_0000, 1'b1);
        queue_eval(OP_SHL, SIZE_BYTE, 32'h0000_0081, 32'd1, 32'h0000_0102, 1'b0);
        queue_eval(OP_SHL, SIZE_BYTE, 32'h0000_0001, 32'd8, 32'h0000_0100, 1'b0);
        // shift count beyond the operand width, then zero count
        queue_eval(OP_SHL, SIZE_BYTE, 32'hffff_ffff, 32'd9, 32'h0000_0000, 1'b1);
        queue_eval(OP_SHL, SIZE_WORD, 32'h0000_8000, 32'd0, 32'h0000_8000, 1'b1);
        queue_eval(OP_SHR, SIZE_DWORD, 32'h8000_0001, 32'd1, 32'h4000_0000, 1'b0);
        queue_eval(OP_SHR, SIZE_DWORD, 32'h8000_0000, 32'd32, 32'h0000_0000, 1'b0);
        // right shift counts past 32 shift nothing out
        queue_eval(OP_SHR, SIZE_DWORD, 32'hffff_ffff, 32'd33, 32'h0000_0000, 1'b1);
        queue_eval(OP_SAR, SIZE_WORD, 32'hffff_8004, 32'hffff_ffff, 32'h0000_ffff, 1'b0);
        queue_eval(OP_SAR, SIZE_WORD, 32'h0000_8004, 32'd3, 32'h0000_f000, 1'b1);
        queue_eval(OP_INC, SIZE_BYTE, 32'h0000_007f, 32'd1, 32'h0000_0080, 1'b1);
        queue_eval(OP_DEC, SIZE_WORD, 32'h0000_8000, 32'd1, 32'h0000_7fff, 1'b0);
        queue_eval(OP_INC, SIZE_DWORD, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 1'b0);
        queue_eval(OP_NONE, SIZE_BYTE, 32'h0000_0010, 32'h0, 32'h0000_0000, 1'b1);
        // unknown kinds act as none
        queue_eval(4'hf, SIZE_WORD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        queue_eval(OP_NONE + 4'd1, SIZE_DWORD, 32'h0, 32'h0, 32'h8000_0000, 1'b0);
        // odd sizes decode as a dword
        queue_eval(OP_ADD, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0);
        queue_eval(OP_SUB, 3'd7, 32'h0000_0001, 32'h0000_0002, 32'hffff_ffff, 1'b0);
        queue_restore(32'hffff_ffff);
        queue_restore(32'h0000_0000);
        queue_restore(32'h0000_0041);

        // Random: alternate idle-free bursts with random gaps.
        no_idle = 1'b0;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
            gap = no_idle ? 4'd0 : 4'($urandom_range(0, 9));
            push_request(random_request(gap));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait for every request to be taken and every result to come back.
        while (requests_taken < requests_total) @(posedge i_clk);
        while (expected_flags.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
